// ===== src/uvsct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsct_pkg
// shared types, constants and the quarter-wave sine generator of the
// uv sphere cell tessellator
// ----------------------------------------------------------------------------
package uvsct_pkg;

  localparam int unsigned MaxDivisionsDef  = 64;
  localparam int unsigned SineTableBitsDef = 10;

  localparam int unsigned CellW   = 6;
  localparam int unsigned NRegW   = 7;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned FracW   = 17;
  localparam int unsigned CoordW  = 17;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned DivW    = 64;
  localparam int unsigned SqrtW   = 34;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 56;

  localparam logic [CfgIdxW-1:0] REG_SUBDIV = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RADIUS = 2'd1;

  localparam logic [NRegW-1:0]   SUBDIV_RST = 7'd5;
  localparam logic [RadiusW-1:0] RADIUS_RST = 16'd256;

  localparam logic [SlotW-1:0] SLOT_FIRST = 3'd0;
  localparam logic [SlotW-1:0] SLOT_LAST  = 3'd5;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // per grid row: radial scale p and signed height fraction
  typedef struct packed {
    logic             ysgn;
    logic [FracW-1:0] ymag;
    logic [FracW-1:0] p16;
  } row_vals_t;

  // what the front hands to the back for one cell
  typedef struct packed {
    logic      bad;
    row_vals_t lo;
    row_vals_t hi;
  } cell_hdr_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             bad;
    logic             last;
  } vtx_tag_t;

  // slot order BL, TR, BR, BL, TL, TR: lower row (i+1) and right column (j+1)
  function automatic logic row_hi(input logic [SlotW-1:0] slot);
    logic r;
    case (slot)
      3'd0, 3'd2, 3'd3: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic col_hi(input logic [SlotW-1:0] slot);
    logic r;
    case (slot)
      3'd1, 3'd2, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // quarter-wave entry m: taylor series in q30, rounded to q16
  function automatic logic [FracW-1:0] qw_entry(input int unsigned m, input int unsigned stb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (HALF_PI_Q30 * 64'(m)) >> (stb - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    if (sum < 0) sum = 0;
    r = (64'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[FracW-1:0];
  endfunction

endpackage

// ===== src/uv_sphere_cell_tessellator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_cell_tessellator_core
// turns one uv sphere grid cell into six q8.8 vertices, two triangles
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_axis   in   tvalid / tready        tdata: cell_row [5:0], cell_col [11:6]
//  m_axis   out  tvalid / tready        tdata: pos_x, pos_y, pos_z, vertex_slot
//                                       tuser: bad_cell, tlast: last_vertex
//  cfg      in   cfg_valid / cfg_ready  cfg_index: 0 subdivisions, 1 radius
//
//  a valid cell gives six results, a bad cell one.
//  after reset and after each subdivisions write the row and column tables
//  are rebuilt by a bit-serial divider and square root while s_axis_tready
//  is low.
//  a stall on m_axis freezes the vertex pipeline; the two-entry cell queue
//  keeps accepting until it is full.
module uv_sphere_cell_tessellator_core #(
  parameter int unsigned MAX_DIVISIONS   = uvsct_pkg::MaxDivisionsDef,
  parameter int unsigned SINE_TABLE_BITS = uvsct_pkg::SineTableBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [uvsct_pkg::InDataW-1:0]     s_axis_tdata,   // cell_row, cell_col
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [uvsct_pkg::OutDataW-1:0]    m_axis_tdata,   // pos_x, pos_y, pos_z, vertex_slot
  output logic [0:0]                        m_axis_tuser,   // bad_cell
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [uvsct_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [uvsct_pkg::RadiusW-1:0]     cfg_data_i
);
  import uvsct_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_DIVISIONS + 1);
  localparam int unsigned CMW = (NW > NRegW) ? NW : NRegW;

  logic [NRegW-1:0]   n_q;
  logic [RadiusW-1:0] radius_q;
  logic               start_q;
  logic               cfg_we, wr_subdiv;
  logic [NW-1:0]      n_eff;

  logic               tbl_busy, tbl_we;
  logic [NW-1:0]      tbl_waddr;
  row_vals_t          tbl_row;
  logic [SINE_TABLE_BITS-1:0] tbl_k;

  logic               re;
  logic [NW-1:0]      ra0, ra1, ca0, ca1;
  row_vals_t          row_lo, row_hi;
  logic [SINE_TABLE_BITS-1:0] k_lo, k_hi;

  logic               q_valid, q_pop;
  cell_hdr_t          q_hdr;
  logic [SINE_TABLE_BITS-1:0] q_k_lo, q_k_hi;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign wr_subdiv   = cfg_we && (cfg_index_i == REG_SUBDIV);
  assign n_eff = (CMW'(n_q) > CMW'(MAX_DIVISIONS)) ? NW'(MAX_DIVISIONS) : NW'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= SUBDIV_RST;
      radius_q <= RADIUS_RST;
      start_q  <= 1'b1;
    end else begin
      start_q <= wr_subdiv;
      if (wr_subdiv) n_q <= cfg_data_i[NRegW-1:0];
      if (cfg_we && cfg_index_i == REG_RADIUS) radius_q <= cfg_data_i;
    end
  end

  uvsct_table_build #(
    .MAX_DIVISIONS  (MAX_DIVISIONS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_build (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .n_i    (n_eff),
    .busy_o (tbl_busy),
    .we_o   (tbl_we),
    .waddr_o(tbl_waddr),
    .row_o  (tbl_row),
    .k_o    (tbl_k)
  );

  uvsct_ram #(
    .WIDTH($bits(row_vals_t)),
    .DEPTH(MAX_DIVISIONS + 1)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_row),
    .re_i    (re),
    .raddr0_i(ra0),
    .raddr1_i(ra1),
    .rdata0_o(row_lo),
    .rdata1_o(row_hi)
  );

  uvsct_ram #(
    .WIDTH(SINE_TABLE_BITS),
    .DEPTH(MAX_DIVISIONS + 1)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_k),
    .re_i    (re),
    .raddr0_i(ca0),
    .raddr1_i(ca1),
    .rdata0_o(k_lo),
    .rdata1_o(k_hi)
  );

  uvsct_front #(
    .MAX_DIVISIONS  (MAX_DIVISIONS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .n_i          (n_eff),
    .tbl_busy_i   (tbl_busy),
    .re_o         (re),
    .row_addr0_o  (ra0),
    .row_addr1_o  (ra1),
    .col_addr0_o  (ca0),
    .col_addr1_o  (ca1),
    .row_lo_i     (row_lo),
    .row_hi_i     (row_hi),
    .k_lo_i       (k_lo),
    .k_hi_i       (k_hi),
    .q_valid_o    (q_valid),
    .q_hdr_o      (q_hdr),
    .q_k_lo_o     (q_k_lo),
    .q_k_hi_o     (q_k_hi),
    .q_pop_i      (q_pop)
  );

  uvsct_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_hdr_i      (q_hdr),
    .q_k_lo_i     (q_k_lo),
    .q_k_hi_i     (q_k_hi),
    .q_pop_o      (q_pop),
    .radius_i     (radius_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // no cell enters while the tables are being rebuilt
  a_no_accept_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !tbl_busy)
    else $error("cell accepted during table build");

  // a subdivisions write always starts a rebuild
  a_rebuild_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_subdiv |=> tbl_busy)
    else $error("no table rebuild after subdivisions write");

  // a bad cell is one zeroed result that closes the cell
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("bad cell result malformed");

  // a good cell closes only on its sixth vertex
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tlast == (m_axis_tdata[3*CoordW +: SlotW] == SLOT_LAST)))
    else $error("last flag out of step with slot");

endmodule

// ===== src/uvsct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsct_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module uvsct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ===== src/uvsct_table_build.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsct_table_build
// sweeps the grid indices 0..N and fills the row and column tables with
// bit-serial division and square root
// ----------------------------------------------------------------------------
module uvsct_table_build #(
  parameter int unsigned MAX_DIVISIONS   = uvsct_pkg::MaxDivisionsDef,
  parameter int unsigned SINE_TABLE_BITS = uvsct_pkg::SineTableBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0]     n_i,
  output logic                                   busy_o,
  output logic                                   we_o,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0]     waddr_o,
  output uvsct_pkg::row_vals_t                   row_o,
  output logic [SINE_TABLE_BITS-1:0]             k_o
);
  import uvsct_pkg::*;

  localparam int unsigned NW = $clog2(MAX_DIVISIONS + 1);
  localparam int unsigned PW = 2 * NW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIVP  = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_DIVY  = 3'd3;
  localparam logic [2:0] ST_DIVK  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  localparam logic [5:0] DIV_LAST  = 6'(DivW - 1);
  localparam logic [5:0] SQRT_LAST = 6'(SqrtW / 2 - 1);

  logic [2:0]       state_q, state_d;
  logic [NW-1:0]    t_q, t_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [PW-1:0]    rem_q, rem_d;
  logic [PW-1:0]    dsr_q, dsr_d;
  logic [SqrtW-1:0] rad_q, rad_d;
  logic [19:0]      srem_q, srem_d;
  logic [FracW-1:0] root_q, root_d;
  logic [FracW-1:0] p_q, p_d;
  logic [FracW-1:0] y_q, y_d;
  logic             ysgn_q, ysgn_d;

  logic [PW:0]      rem_sh;
  logic             div_ge;
  logic [19:0]      srem_sh;
  logic [19:0]      trial;
  logic             sq_ge;
  logic [PW-1:0]    n_sq;
  logic [NW:0]      two_t;
  logic [NW:0]      dmag;

  // p numerator 4*t*(N-t) for the index about to be processed
  function automatic logic [PW-1:0] num_p_next(input logic [NW-1:0] t,
                                               input logic [NW-1:0] n);
    logic [PW-1:0] r;
    r = PW'(PW'(t) * PW'(n - t)) << 2;
    return r;
  endfunction

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DivW-1]};
    div_ge  = rem_sh >= {1'b0, dsr_q};
    srem_sh = {srem_q[17:0], rad_q[SqrtW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    sq_ge   = srem_sh >= trial;
    n_sq    = PW'(n_i) * PW'(n_i);
    two_t   = {t_q, 1'b0};
    dmag    = ({1'b0, n_i} >= two_t) ? ({1'b0, n_i} - two_t) : (two_t - {1'b0, n_i});
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    p_d     = p_q;
    y_d     = y_q;
    ysgn_d  = ysgn_q;
    case (state_q)
      ST_DIVP, ST_DIVY, ST_DIVK: begin
        rem_d = div_ge ? PW'(rem_sh - {1'b0, dsr_q}) : PW'(rem_sh);
        dvd_d = {dvd_q[DivW-2:0], div_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == ST_DIVP) begin
            rad_d   = dvd_d[SqrtW-1:0];
            srem_d  = '0;
            root_d  = '0;
            state_d = ST_SQRT;
          end else if (state_q == ST_DIVY) begin
            y_d     = dvd_d[FracW-1:0];
            dvd_d   = (DivW'(t_q) << SINE_TABLE_BITS) + DivW'(n_i >> 1);
            dsr_d   = PW'(n_i);
            state_d = ST_DIVK;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_SQRT: begin
        srem_d = sq_ge ? (srem_sh - trial) : srem_sh;
        root_d = {root_q[FracW-2:0], sq_ge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          p_d     = root_d;
          dvd_d   = DivW'(dmag) << 16;
          dsr_d   = PW'(n_i);
          ysgn_d  = two_t > {1'b0, n_i};
          state_d = ST_DIVY;
        end
      end
      ST_WRITE: begin
        if (t_q == n_i) begin
          state_d = ST_IDLE;
        end else begin
          t_d     = t_q + NW'(1);
          state_d = ST_DIVP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // the entry setup for the p division of each next index sits here; a
    // start sets up its own below
    if (state_d == ST_DIVP && state_q != ST_DIVP) begin
      dvd_d = DivW'(num_p_next(t_d, n_i)) << 32;
      dsr_d = n_sq;
      rem_d = '0;
      cnt_d = '0;
    end
    // index 0 has a zero p numerator, so the dividend starts cleared
    if (start_i) begin
      t_d     = '0;
      cnt_d   = '0;
      rem_d   = '0;
      dvd_d   = '0;
      dsr_d   = n_sq;
      state_d = (n_i == '0) ? ST_IDLE : ST_DIVP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    p_q    <= p_d;
    y_q    <= y_d;
    ysgn_q <= ysgn_d;
  end

  assign busy_o     = start_i || (state_q != ST_IDLE);
  assign we_o       = (state_q == ST_WRITE);
  assign waddr_o    = t_q;
  assign row_o.ysgn = ysgn_q;
  assign row_o.ymag = y_q;
  assign row_o.p16  = p_q;
  assign k_o        = dvd_q[SINE_TABLE_BITS-1:0];

endmodule

// ===== src/uvsct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsct_front
// accepts cells, flags bad ones, reads the grid tables and queues the cell
// ----------------------------------------------------------------------------
module uvsct_front #(
  parameter int unsigned MAX_DIVISIONS   = uvsct_pkg::MaxDivisionsDef,
  parameter int unsigned SINE_TABLE_BITS = uvsct_pkg::SineTableBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [uvsct_pkg::InDataW-1:0]          s_axis_tdata,
  input  logic [$clog2(MAX_DIVISIONS+1)-1:0]     n_i,
  input  logic                                   tbl_busy_i,
  output logic                                   re_o,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0]     row_addr0_o,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0]     row_addr1_o,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0]     col_addr0_o,
  output logic [$clog2(MAX_DIVISIONS+1)-1:0]     col_addr1_o,
  input  uvsct_pkg::row_vals_t                   row_lo_i,
  input  uvsct_pkg::row_vals_t                   row_hi_i,
  input  logic [SINE_TABLE_BITS-1:0]             k_lo_i,
  input  logic [SINE_TABLE_BITS-1:0]             k_hi_i,
  output logic                                   q_valid_o,
  output uvsct_pkg::cell_hdr_t                   q_hdr_o,
  output logic [SINE_TABLE_BITS-1:0]             q_k_lo_o,
  output logic [SINE_TABLE_BITS-1:0]             q_k_hi_o,
  input  logic                                   q_pop_i
);
  import uvsct_pkg::*;

  localparam int unsigned NW = $clog2(MAX_DIVISIONS + 1);
  localparam int unsigned CW = (NW > CellW) ? NW : CellW;

  logic [CellW-1:0] row, col;
  logic             accept, bad;
  logic             s1_valid_q, s1_bad_q;
  logic             push;

  cell_hdr_t                  q_hdr_q [2];
  logic [SINE_TABLE_BITS-1:0] q_klo_q [2];
  logic [SINE_TABLE_BITS-1:0] q_khi_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 cnt_q;

  assign row    = s_axis_tdata[CellW-1:0];
  assign col    = s_axis_tdata[2*CellW-1:CellW];
  assign bad    = (CW'(row) >= CW'(n_i)) || (CW'(col) >= CW'(n_i));
  assign push   = s1_valid_q && (cnt_q != 2'd2);

  assign s_axis_tready = !tbl_busy_i && (!s1_valid_q || (cnt_q != 2'd2));
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign re_o        = accept;
  assign row_addr0_o = NW'(row);
  assign row_addr1_o = NW'(row) + NW'(1);
  assign col_addr0_o = NW'(col);
  assign col_addr1_o = NW'(col) + NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (push) begin
        s1_valid_q <= 1'b0;
      end
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_bad_q <= bad;
    if (push) begin
      q_hdr_q[wr_ptr_q] <= '{bad: s1_bad_q, lo: row_lo_i, hi: row_hi_i};
      q_klo_q[wr_ptr_q] <= k_lo_i;
      q_khi_q[wr_ptr_q] <= k_hi_i;
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_hdr_o   = q_hdr_q[rd_ptr_q];
  assign q_k_lo_o  = q_klo_q[rd_ptr_q];
  assign q_k_hi_o  = q_khi_q[rd_ptr_q];

endmodule

// ===== src/uvsct_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsct_back
// walks the six vertex slots of a queued cell, or the single slot of a bad one,
// through a five-stage sine, scale and radius pipeline
// ----------------------------------------------------------------------------
module uvsct_back #(
  parameter int unsigned SINE_TABLE_BITS = uvsct_pkg::SineTableBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  uvsct_pkg::cell_hdr_t                q_hdr_i,
  input  logic [SINE_TABLE_BITS-1:0]          q_k_lo_i,
  input  logic [SINE_TABLE_BITS-1:0]          q_k_hi_i,
  output logic                                q_pop_o,
  input  logic [uvsct_pkg::RadiusW-1:0]       radius_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [uvsct_pkg::OutDataW-1:0]      m_axis_tdata,   // pos_x, pos_y, pos_z, vertex_slot
  output logic [0:0]                          m_axis_tuser,   // bad_cell
  output logic                                m_axis_tlast
);
  import uvsct_pkg::*;

  localparam int unsigned STB = SINE_TABLE_BITS;
  localparam int unsigned QTR = 1 << (STB - 2);
  localparam int unsigned QIW = STB - 1;
  localparam int unsigned PRODW = 2 * FracW;
  localparam int unsigned RPRODW = FracW + RadiusW;

  logic [FracW-1:0] qw_rom [QTR+1];

  for (genvar m = 0; m <= QTR; m++) begin : g_rom
    assign qw_rom[m] = qw_entry(m, STB);
  end

  // current cell
  logic                 cur_valid_q;
  cell_hdr_t            cur_hdr_q;
  logic [STB-1:0]       cur_klo_q, cur_khi_q;
  logic [SlotW-1:0]     slot_q;
  logic                 en, issue, done_cur, pop;

  // stage a: table picks
  logic                 a_v_q;
  vtx_tag_t             a_tag_q;
  logic [FracW-1:0]     a_p_q, a_ym_q;
  logic [FracW-1:0]     a_sm_q [2];
  logic [1:0]           a_sn_q;
  logic                 a_yn_q;
  // stage b: p times sine
  logic                 b_v_q;
  vtx_tag_t             b_tag_q;
  logic [PRODW-1:0]     b_pr_q [2];
  logic [1:0]           b_sn_q;
  logic [FracW-1:0]     b_ym_q;
  logic                 b_yn_q;
  // stage c: rounded fractions
  logic                 c_v_q;
  vtx_tag_t             c_tag_q;
  logic [FracW-1:0]     c_f_q [3];
  logic [2:0]           c_n_q;
  // stage d: times radius
  logic                 d_v_q;
  vtx_tag_t             d_tag_q;
  logic [RPRODW-1:0]    d_m_q [3];
  logic [2:0]           d_n_q;
  // output stage
  logic                 e_v_q;
  vtx_tag_t             e_tag_q;
  logic [CoordW-1:0]    e_c_q [3];

  row_vals_t            rsel;
  logic [STB-1:0]       ksel;
  logic [STB-1:0]       kk [2];
  logic [1:0]           quad [2];
  logic [QIW-1:0]       qi [2];
  logic [FracW-1:0]     smag [2];
  logic [1:0]           sneg;
  logic [CoordW-1:0]    coord [3];
  logic [RPRODW-1:0]    rnd [3];

  assign en       = !e_v_q || m_axis_tready;
  assign issue    = cur_valid_q && en;
  assign done_cur = issue && (cur_hdr_q.bad || slot_q == SLOT_LAST);
  assign pop      = q_valid_i && (!cur_valid_q || done_cur);
  assign q_pop_o  = pop;

  always_comb begin
    rsel  = row_hi(slot_q) ? cur_hdr_q.hi : cur_hdr_q.lo;
    ksel  = col_hi(slot_q) ? cur_khi_q : cur_klo_q;
    kk[0] = ksel;
    kk[1] = ksel + STB'(QTR);   // cosine is a quarter turn ahead
    for (int l = 0; l < 2; l++) begin
      quad[l] = kk[l][STB-1 -: 2];
      qi[l]   = quad[l][0] ? (QIW'(QTR) - {1'b0, kk[l][STB-3:0]}) : {1'b0, kk[l][STB-3:0]};
      smag[l] = qw_rom[qi[l]];
      sneg[l] = quad[l][1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      slot_q      <= SLOT_FIRST;
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      d_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
        slot_q      <= SLOT_FIRST;
      end else begin
        if (done_cur) cur_valid_q <= 1'b0;
        if (issue) slot_q <= slot_q + SlotW'(1);
      end
      if (en) begin
        a_v_q <= issue;
        b_v_q <= a_v_q;
        c_v_q <= b_v_q;
        d_v_q <= c_v_q;
        e_v_q <= d_v_q;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l]   = (d_m_q[l] + RPRODW'(32768)) >> 16;
      coord[l] = d_n_q[l] ? (CoordW'(0) - CoordW'(rnd[l])) : CoordW'(rnd[l]);
      if (d_tag_q.bad) coord[l] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_hdr_q <= q_hdr_i;
      cur_klo_q <= q_k_lo_i;
      cur_khi_q <= q_k_hi_i;
    end
    if (en) begin
      a_tag_q   <= '{slot: slot_q, bad: cur_hdr_q.bad,
                     last: cur_hdr_q.bad || (slot_q == SLOT_LAST)};
      a_p_q     <= rsel.p16;
      a_ym_q    <= rsel.ymag;
      a_yn_q    <= rsel.ysgn;
      a_sm_q[0] <= smag[0];
      a_sm_q[1] <= smag[1];
      a_sn_q    <= sneg;

      b_tag_q   <= a_tag_q;
      b_pr_q[0] <= PRODW'(a_p_q) * PRODW'(a_sm_q[0]);
      b_pr_q[1] <= PRODW'(a_p_q) * PRODW'(a_sm_q[1]);
      b_sn_q    <= a_sn_q;
      b_ym_q    <= a_ym_q;
      b_yn_q    <= a_yn_q;

      c_tag_q   <= b_tag_q;
      c_f_q[0]  <= FracW'((b_pr_q[0] + PRODW'(32768)) >> 16);
      c_f_q[1]  <= b_ym_q;
      c_f_q[2]  <= FracW'((b_pr_q[1] + PRODW'(32768)) >> 16);
      c_n_q     <= {b_sn_q[1], b_yn_q, b_sn_q[0]};

      d_tag_q   <= c_tag_q;
      for (int l = 0; l < 3; l++) begin
        d_m_q[l] <= RPRODW'(c_f_q[l]) * RPRODW'(radius_i);
      end
      d_n_q     <= c_n_q;

      e_tag_q   <= d_tag_q;
      for (int l = 0; l < 3; l++) begin
        e_c_q[l] <= coord[l];
      end
    end
  end

  assign m_axis_tvalid = e_v_q;
  assign m_axis_tdata  = {(OutDataW - 3*CoordW - SlotW)'(0), e_tag_q.slot,
                          e_c_q[2], e_c_q[1], e_c_q[0]};
  assign m_axis_tuser  = e_tag_q.bad;
  assign m_axis_tlast  = e_tag_q.last;

endmodule

// ===== test/uv_sphere_cell_tessellator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_cell_tessellator_core_test
// self-checking bench: grid cells go in on s_axis, every vertex coming out on
// m_axis is checked against a fixed-point vertex predictor kept in the bench;
// subdivisions and radius are swept between phases, both sides idle at random
// ----------------------------------------------------------------------------
module uv_sphere_cell_tessellator_core_test;
  import uvsct_pkg::*;

  localparam int unsigned  SINE_BITS  = 10;
  localparam int unsigned  QTR        = 1 << (SINE_BITS - 2);
  localparam int unsigned  N_LIMIT    = 64;
  localparam int unsigned  IDLE_LIMIT = 60000;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [SlotW-1:0]         slot;
    logic                     bad;
    logic                     last;
  } vertex_t;

  typedef struct packed {
    logic [CellW-1:0] row;
    logic [CellW-1:0] col;
  } cell_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RadiusW-1:0] cfg_data_i;

  uv_sphere_cell_tessellator_core u_dut (.*);

  cell_t   cell_q[$];
  vertex_t vertex_q[$];
  longint  qwave[0:QTR];
  logic [NRegW-1:0]   n_shadow;
  logic [RadiusW-1:0] r_shadow;
  int  err_count, idle_cycles;
  int  gap_max, stall_max, tx_gap, rx_wait, rx_hold;
  logic s_fire, m_fire, cfg_fire;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // quarter-wave sine, taylor series in q30
  function automatic void fill_sine();
    longint unsigned x, x2, term;
    longint sum;
    for (int m = 0; m <= QTR; m++) begin
      x    = 64'd1686629713 * m / QTR;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) sum = 65536;
      qwave[m] = sum;
    end
  endfunction

  function automatic longint sine16(longint unsigned idx);
    longint unsigned off, quad;
    idx  = idx & ((1 << SINE_BITS) - 1);
    quad = idx >> (SINE_BITS - 2);
    off  = idx & (QTR - 1);
    case (quad)
      0:       return qwave[off];
      1:       return qwave[QTR - off];
      2:       return -qwave[off];
      default: return -qwave[QTR - off];
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_mul(longint unsigned a, longint b);
    longint unsigned mag;
    longint v;
    mag = (b < 0) ? -b : b;
    v   = (a * mag + 32768) >> 16;
    return (b < 0) ? -v : v;
  endfunction

  function automatic vertex_t grid_vertex(int n, int a, int b);
    vertex_t v;
    longint unsigned p16, k;
    longint diff, y16;
    p16  = root_floor((longint'(4 * a * (n - a)) << 32) / (n * n));
    diff = n - 2 * a;
    y16  = ((diff < 0 ? -diff : diff) * 65536) / n;
    if (diff < 0) y16 = -y16;
    k    = ((longint'(b) << SINE_BITS) + n / 2) / n;
    v    = '0;
    v.x  = CoordW'(round_mul(r_shadow, round_mul(p16, sine16(k))));
    v.y  = CoordW'(round_mul(r_shadow, y16));
    v.z  = CoordW'(round_mul(r_shadow, round_mul(p16, sine16(k + QTR))));
    return v;
  endfunction

  function automatic void put_cell(logic [CellW-1:0] r, logic [CellW-1:0] c);
    cell_t cl;
    cl.row = r;
    cl.col = c;
    cell_q.insert(cell_q.size(), cl);
  endfunction

  // vertex order BL, TR, BR, BL, TL, TR
  function automatic void predict_cell(cell_t c);
    int n;
    vertex_t v;
    int row_step[6] = '{1, 0, 1, 1, 0, 0};
    int col_step[6] = '{0, 1, 1, 0, 0, 1};
    n = (n_shadow > N_LIMIT) ? N_LIMIT : n_shadow;
    if (c.row >= n || c.col >= n) begin
      v      = '0;
      v.bad  = 1'b1;
      v.last = 1'b1;
      vertex_q.insert(vertex_q.size(), v);
      return;
    end
    for (int s = 0; s < 6; s++) begin
      v      = grid_vertex(n, c.row + row_step[s], c.col + col_step[s]);
      v.slot = SlotW'(s);
      v.last = (v.slot == SLOT_LAST);
      vertex_q.insert(vertex_q.size(), v);
    end
  endfunction

  // handshake sampling, prediction and checking
  always @(posedge clk_i) begin
    vertex_t got, want;
    s_fire   <= s_axis_tvalid && s_axis_tready;
    m_fire   <= m_axis_tvalid && m_axis_tready;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SUBDIV) n_shadow = cfg_data_i[NRegW-1:0];
      else if (cfg_index_i == REG_RADIUS) r_shadow = cfg_data_i;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      predict_cell('{row: s_axis_tdata[CellW-1:0], col: s_axis_tdata[2*CellW-1:CellW]});
    end
    if (m_axis_tvalid && m_axis_tready) begin
      rx_wait = $urandom_range(0, stall_max);
      got = {m_axis_tdata[CoordW-1:0], m_axis_tdata[2*CoordW-1:CoordW],
             m_axis_tdata[3*CoordW-1:2*CoordW], m_axis_tdata[3*CoordW+SlotW-1:3*CoordW],
             m_axis_tuser[0], m_axis_tlast};
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex %h", got);
        err_count++;
      end else begin
        want = vertex_q.pop_front();
        if (got.x != want.x) begin
          $error("pos_x expected %0d got %0d", want.x, got.x); err_count++;
        end
        if (got.y != want.y) begin
          $error("pos_y expected %0d got %0d", want.y, got.y); err_count++;
        end
        if (got.z != want.z) begin
          $error("pos_z expected %0d got %0d", want.z, got.z); err_count++;
        end
        if (got.slot != want.slot) begin
          $error("vertex_slot expected %0d got %0d", want.slot, got.slot); err_count++;
        end
        if (got.bad != want.bad) begin
          $error("bad_cell expected %0d got %0d", want.bad, got.bad); err_count++;
        end
        if (got.last != want.last) begin
          $error("last_vertex expected %0d got %0d", want.last, got.last); err_count++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // cell request driver
  always @(negedge clk_i) begin
    cell_t c;
    if (rst_ni && !(s_axis_tvalid && !s_fire)) begin
      if (s_fire) tx_gap = $urandom_range(0, gap_max);
      if (tx_gap > 0 || cell_q.size() == 0) begin
        if (tx_gap > 0) tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else begin
        c = cell_q.pop_front();
        s_axis_tdata  <= InDataW'({c.col, c.row});
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // vertex receiver
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cell_q.size() != 0 || s_axis_tvalid || vertex_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RadiusW-1:0] val);
    wait_idle();
    repeat (20) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_cells(int count, int in_range_pct);
    int n;
    cell_t c;
    n = (n_shadow > N_LIMIT) ? N_LIMIT : n_shadow;
    for (int i = 0; i < count; i++) begin
      if (n > 0 && $urandom_range(0, 99) < in_range_pct) begin
        c.row = $urandom_range(0, n - 1);
        c.col = $urandom_range(0, n - 1);
      end else begin
        c.row = $urandom_range(0, 63);
        c.col = $urandom_range(0, 63);
      end
      cell_q.insert(cell_q.size(), c);
    end
  endtask

  initial begin
    int n_set[10]          = '{1, 64, 2, 0, 16'hFFC7, 3, 7, 33, 64, 5};
    logic [15:0] r_set[10] = '{16'hFFFF, 16'hFFFF, 16'd1, 16'd256, 16'd0,
                               16'd300, 16'd0, 16'd0, 16'd0, 16'd256};
    fill_sine();
    n_shadow = SUBDIV_RST;
    r_shadow = RADIUS_RST;
    err_count = 0; idle_cycles = 0;
    gap_max = 17; stall_max = 17; tx_gap = 0; rx_wait = 0; rx_hold = 0;
    s_fire = 1'b0; m_fire = 1'b0; cfg_fire = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = REG_SUBDIV; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners at reset settings
    put_cell(6'd0, 6'd0);
    put_cell(6'd4, 6'd4);
    put_cell(6'd0, 6'd4);
    put_cell(6'd4, 6'd0);
    put_cell(6'd2, 6'd3);
    put_cell(6'd5, 6'd0);
    put_cell(6'd0, 6'd5);
    put_cell(6'd63, 6'd63);
    put_cell(6'd1, 6'd2);
    put_cell(6'd3, 6'd1);
    wait_idle();
    write_reg(REG_SPARE, 16'h0003);
    put_cell(6'd4, 6'd4);

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_SUBDIV, 16'(n_set[p]));
      write_reg(REG_RADIUS, (r_set[p] == 0) ? 16'($urandom) : r_set[p]);
      gap_max   = (p % 3 == 1) ? 0 : 17;
      stall_max = (p % 4 == 2) ? 0 : 17;
      if (n_shadow == N_LIMIT) begin
        put_cell(6'd63, 6'd63);
        put_cell(6'd0, 6'd63);
        put_cell(6'd63, 6'd0);
      end
      add_cells(35, 85);
      // long receiver hold-off once the tables are ready and cells flow
      if (p == 1 || p == 6) begin
        do @(negedge clk_i);
        while (!s_fire);
        rx_hold = 400;
      end
    end

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/uvsct_pkg.sv
src/uvsct_ram.sv
src/uvsct_table_build.sv
src/uvsct_front.sv
src/uvsct_back.sv
src/uv_sphere_cell_tessellator_core.sv
test/uv_sphere_cell_tessellator_core_test.sv
